FILE: rtl/dess_pkg.sv
// shared types, constants and register codes for the dual encoder speed sampler
package dess_pkg;

	localparam int COUNT_WIDTH_DEF = 32;
	localparam int RPM_FRAC_DEF    = 8;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int DELTA_W  = 16;
	localparam int TOTAL_W  = 32;
	localparam int RPM_W    = 32;
	localparam int MUL_A_W  = 32;
	localparam int MUL_B_W  = 16;
	localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
	// ppr(16) * ratio(10) * quad(3) * period(16)
	localparam int DEN_W    = 45;
	// magnitude(15) * 60000(16)
	localparam int SCALED_W = 31;

	localparam logic [15:0] DEF_PPR       = 16'd11;
	localparam logic [9:0]  DEF_RATIO     = 10'd30;
	localparam logic [2:0]  DEF_QUAD      = 3'd4;
	localparam logic [14:0] DEF_MAX_DELTA = 15'd2000;
	localparam logic        DEF_LEFT_INV  = 1'b1;
	localparam logic        DEF_RIGHT_INV = 1'b0;
	localparam logic [15:0] MS_PER_MINUTE = 16'd60000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PPR   = 3'd0,
		REG_RATIO = 3'd1,
		REG_QUAD  = 3'd2,
		REG_LINV  = 3'd3,
		REG_RINV  = 3'd4,
		REG_MAXD  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0] ppr;
		logic [9:0]  ratio;
		logic [2:0]  quad;
		logic        left_inv;
		logic        right_inv;
		logic [14:0] max_delta;
	} cfg_t;

	typedef enum logic [1:0] {
		ALU_HOLD,
		ALU_MUL,
		ALU_DIV_LOAD,
		ALU_DIV_STEP
	} alu_op_t;

	typedef struct packed {
		alu_op_t              op;
		logic [MUL_A_W-1:0]   mul_a;
		logic [MUL_B_W-1:0]   mul_b;
	} alu_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_PR,
		ST_MUL_Q,
		ST_MUL_P,
		ST_MUL_N,
		ST_DIV_LOAD,
		ST_DIV,
		ST_SAT
	} seq_state_t;

endpackage

FILE: rtl/dess_cfg.sv
// configuration registers with zero-selects-default resolution for ppr, ratio, quad and max_delta
module dess_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [dess_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dess_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output dess_pkg::cfg_t                  cfg
);
	import dess_pkg::*;

	logic [15:0] ppr_q;
	logic [9:0]  ratio_q;
	logic [2:0]  quad_q;
	logic        linv_q;
	logic        rinv_q;
	logic [14:0] maxd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppr_q   <= DEF_PPR;
			ratio_q <= DEF_RATIO;
			quad_q  <= DEF_QUAD;
			linv_q  <= DEF_LEFT_INV;
			rinv_q  <= DEF_RIGHT_INV;
			maxd_q  <= DEF_MAX_DELTA;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_PPR:   ppr_q   <= cfg_wdata[15:0];
				REG_RATIO: ratio_q <= cfg_wdata[9:0];
				REG_QUAD:  quad_q  <= cfg_wdata[2:0];
				REG_LINV:  linv_q  <= cfg_wdata[0];
				REG_RINV:  rinv_q  <= cfg_wdata[0];
				REG_MAXD:  maxd_q  <= cfg_wdata[14:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg.ppr       = (ppr_q == '0) ? DEF_PPR : ppr_q;
		cfg.ratio     = (ratio_q == '0) ? DEF_RATIO : ratio_q;
		cfg.quad      = (quad_q == '0) ? DEF_QUAD : quad_q;
		cfg.left_inv  = linv_q;
		cfg.right_inv = rinv_q;
		cfg.max_delta = (maxd_q == '0) ? DEF_MAX_DELTA : maxd_q;
	end

endmodule

FILE: rtl/dess_side.sv
// per-encoder sign correction, limit check and running count
module dess_side #(
	parameter int COUNT_WIDTH = dess_pkg::COUNT_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  logic [dess_pkg::DELTA_W-1:0] raw,
	input  logic                         invert,
	input  logic [14:0]                  limit,
	output logic [dess_pkg::DELTA_W-1:0] sd,
	output logic                         rej,
	output logic [dess_pkg::DELTA_W-1:0] kept,
	output logic [dess_pkg::TOTAL_W-1:0] total_next
);
	import dess_pkg::*;

	logic [COUNT_WIDTH-1:0] accum_q;
	logic [COUNT_WIDTH-1:0] accum_sum;
	logic [DELTA_W-1:0]     mag;
	logic [63:0]            accum_wide;

	// magnitude of the most negative value is 32768, always above the limit
	assign sd        = invert ? (DELTA_W'(0) - raw) : raw;
	assign mag       = sd[DELTA_W-1] ? (DELTA_W'(0) - sd) : sd;
	assign rej       = mag > {1'b0, limit};
	assign kept      = rej ? '0 : sd;
	assign accum_sum = accum_q + COUNT_WIDTH'($signed(kept));
	assign accum_wide = 64'(accum_sum);
	assign total_next = accum_wide[TOTAL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q <= '0;
		end else if (load) begin
			accum_q <= accum_sum;
		end
	end

endmodule

FILE: rtl/dess_alu.sv
// shared multiplier and one-bit-per-cycle restoring divider
module dess_alu #(
	parameter int NUM_W = dess_pkg::SCALED_W + dess_pkg::RPM_FRAC_DEF
) (
	input  logic                         clk,
	input  dess_pkg::alu_ctrl_t          ctrl,
	input  logic [dess_pkg::DEN_W-1:0]   den,
	input  logic [NUM_W-1:0]             num,
	output logic [dess_pkg::MUL_P_W-1:0] prod,
	output logic [NUM_W-1:0]             quo
);
	import dess_pkg::*;

	logic [MUL_P_W-1:0] prod_q;
	logic [NUM_W-1:0]   quo_q;
	logic [DEN_W-1:0]   rem_q;
	logic [DEN_W:0]     trial;
	logic [DEN_W:0]     diff;
	logic               ge;

	// dividend bits shift out of the top of quo_q as quotient bits enter below
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den};
	assign ge    = trial >= {1'b0, den};

	always_ff @(posedge clk) begin
		case (ctrl.op)
			ALU_MUL: begin
				prod_q <= ctrl.mul_a * ctrl.mul_b;
			end
			ALU_DIV_LOAD: begin
				quo_q <= num;
				rem_q <= '0;
			end
			ALU_DIV_STEP: begin
				quo_q <= {quo_q[NUM_W-2:0], ge};
				rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			end
			default: begin
			end
		endcase
	end

	assign prod = prod_q;
	assign quo  = quo_q;

endmodule

FILE: rtl/dual_encoder_speed_sampler_unit.sv
// dual encoder speed sampler top: sequencer around the shared multiply/divide unit
//
//  channel  signals                                       dir  moves
//  cfg      cfg_we cfg_index cfg_wdata                    in   register write
//  in       in_valid in_stall left_raw right_raw ...      in   one sample item
//  out      out_valid out_stall left_signed ... right_rpm out  one result item
//
// an item is accepted in the idle state; three multiplies build the denominator, then each
// side takes one multiply, a load, a 31+RPM_FRAC_BITS step divide (one quotient bit per
// cycle) and a saturate step.
// in_stall is high from acceptance until the result is moved into the output register,
// which happens only once the previous result has been taken.
// reset returns the configuration registers to their defaults and the running counts to zero.
module dual_encoder_speed_sampler_unit #(
	parameter int COUNT_WIDTH   = dess_pkg::COUNT_WIDTH_DEF,
	parameter int RPM_FRAC_BITS = dess_pkg::RPM_FRAC_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [dess_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dess_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic signed [15:0]              left_raw,
	input  logic signed [15:0]              right_raw,
	input  logic [15:0]                     period_ms,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [15:0]              left_signed,
	output logic signed [15:0]              right_signed,
	output logic                            left_rejected,
	output logic                            right_rejected,
	output logic signed [15:0]              left_speed,
	output logic signed [15:0]              right_speed,
	output logic signed [31:0]              left_total,
	output logic signed [31:0]              right_total,
	output logic signed [31:0]              left_rpm,
	output logic signed [31:0]              right_rpm
);
	import dess_pkg::*;

	localparam int NUM_W = SCALED_W + RPM_FRAC_BITS;
	localparam int CNT_W = $clog2(NUM_W);

	cfg_t       cfg;
	alu_ctrl_t  alu_ctrl;
	seq_state_t state_q, state_d;
	logic       side_q, side_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic       out_valid_q;
	logic       accept, den_ld, rpm_l_ld, out_ld;

	logic [MUL_P_W-1:0] prod;
	logic [NUM_W-1:0]   quo;
	logic [NUM_W-1:0]   num;
	logic [DEN_W-1:0]   den_q;

	logic [DELTA_W-1:0] sd_l, kept_l, sd_r, kept_r;
	logic               rej_l, rej_r;
	logic [TOTAL_W-1:0] total_l, total_r;

	logic [15:0]        period_q;
	logic [DELTA_W-1:0] sd_l_q, sd_r_q, kept_l_q, kept_r_q;
	logic               rej_l_q, rej_r_q;
	logic [TOTAL_W-1:0] total_l_q, total_r_q;
	logic [RPM_W-1:0]   rpm_l_q;

	logic [DELTA_W-1:0] cur_kept, cur_neg;
	logic [14:0]        cur_mag;
	logic [63:0]        q_wide;
	logic [RPM_W-1:0]   q_neg_sat, rpm_cur;

	dess_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	dess_side #(.COUNT_WIDTH(COUNT_WIDTH)) u_left (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (accept),
		.raw        (left_raw),
		.invert     (cfg.left_inv),
		.limit      (cfg.max_delta),
		.sd         (sd_l),
		.rej        (rej_l),
		.kept       (kept_l),
		.total_next (total_l)
	);

	dess_side #(.COUNT_WIDTH(COUNT_WIDTH)) u_right (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (accept),
		.raw        (right_raw),
		.invert     (cfg.right_inv),
		.limit      (cfg.max_delta),
		.sd         (sd_r),
		.rej        (rej_r),
		.kept       (kept_r),
		.total_next (total_r)
	);

	dess_alu #(.NUM_W(NUM_W)) u_alu (
		.clk  (clk),
		.ctrl (alu_ctrl),
		.den  (den_q),
		.num  (num),
		.prod (prod),
		.quo  (quo)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign num      = NUM_W'(prod[SCALED_W-1:0]) << RPM_FRAC_BITS;

	// kept deltas never reach -32768, so 15 bits hold the magnitude
	assign cur_kept = side_q ? kept_r_q : kept_l_q;
	assign cur_neg  = DELTA_W'(0) - cur_kept;
	assign cur_mag  = cur_kept[DELTA_W-1] ? cur_neg[14:0] : cur_kept[14:0];

	// saturate the signed quotient to the signed 32-bit range; a zero period gives zero
	always_comb begin
		q_wide    = 64'(quo);
		q_neg_sat = (q_wide > 64'h8000_0000) ? 32'h8000_0000 : q_wide[RPM_W-1:0];
		if (period_q == '0) begin
			rpm_cur = '0;
		end else if (cur_kept[DELTA_W-1]) begin
			rpm_cur = RPM_W'(0) - q_neg_sat;
		end else begin
			rpm_cur = (q_wide > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q_wide[RPM_W-1:0];
		end
	end

	always_comb begin
		state_d        = state_q;
		side_d         = side_q;
		cnt_d          = cnt_q;
		den_ld         = 1'b0;
		rpm_l_ld       = 1'b0;
		out_ld         = 1'b0;
		alu_ctrl.op    = ALU_HOLD;
		alu_ctrl.mul_a = '0;
		alu_ctrl.mul_b = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_MUL_PR;
				end
			end
			ST_MUL_PR: begin
				alu_ctrl.op    = ALU_MUL;
				alu_ctrl.mul_a = MUL_A_W'(cfg.ppr);
				alu_ctrl.mul_b = MUL_B_W'(cfg.ratio);
				state_d        = ST_MUL_Q;
			end
			ST_MUL_Q: begin
				alu_ctrl.op    = ALU_MUL;
				alu_ctrl.mul_a = prod[MUL_A_W-1:0];
				alu_ctrl.mul_b = MUL_B_W'(cfg.quad);
				state_d        = ST_MUL_P;
			end
			ST_MUL_P: begin
				alu_ctrl.op    = ALU_MUL;
				alu_ctrl.mul_a = prod[MUL_A_W-1:0];
				alu_ctrl.mul_b = period_q;
				state_d        = ST_MUL_N;
			end
			ST_MUL_N: begin
				// denominator is still in the product register on the left pass only
				den_ld         = !side_q;
				alu_ctrl.op    = ALU_MUL;
				alu_ctrl.mul_a = MUL_A_W'(cur_mag);
				alu_ctrl.mul_b = MS_PER_MINUTE;
				state_d        = ST_DIV_LOAD;
			end
			ST_DIV_LOAD: begin
				alu_ctrl.op = ALU_DIV_LOAD;
				cnt_d       = CNT_W'(NUM_W - 1);
				state_d     = ST_DIV;
			end
			ST_DIV: begin
				alu_ctrl.op = ALU_DIV_STEP;
				if (cnt_q == '0) begin
					state_d = ST_SAT;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_SAT: begin
				if (!side_q) begin
					rpm_l_ld = 1'b1;
					side_d   = 1'b1;
					state_d  = ST_MUL_N;
				end else if (!out_valid_q || !out_stall) begin
					out_ld  = 1'b1;
					side_d  = 1'b0;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			side_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			side_q  <= side_d;
			cnt_q   <= cnt_d;
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			period_q  <= period_ms;
			sd_l_q    <= sd_l;
			sd_r_q    <= sd_r;
			rej_l_q   <= rej_l;
			rej_r_q   <= rej_r;
			kept_l_q  <= kept_l;
			kept_r_q  <= kept_r;
			total_l_q <= total_l;
			total_r_q <= total_r;
		end
		if (den_ld) begin
			den_q <= prod[DEN_W-1:0];
		end
		if (rpm_l_ld) begin
			rpm_l_q <= rpm_cur;
		end
		if (out_ld) begin
			left_signed    <= sd_l_q;
			right_signed   <= sd_r_q;
			left_rejected  <= rej_l_q;
			right_rejected <= rej_r_q;
			left_speed     <= kept_l_q;
			right_speed    <= kept_r_q;
			left_total     <= total_l_q;
			right_total    <= total_r_q;
			left_rpm       <= rpm_l_q;
			right_rpm      <= rpm_cur;
		end
	end

	assign out_valid = out_valid_q;

`ifndef ASSERT_OFF
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("sequencer did not leave idle after accepting an item");

	a_result_from_right: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == ST_SAT && $past(side_q)))
		else $error("result raised outside the right-side finish step");

	a_rejected_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && left_rejected) |-> (left_speed == '0 && left_rpm == '0))
		else $error("rejected left delta gave a nonzero speed");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(right_rpm))
		else $error("pending result overwritten");
`endif

endmodule

FILE: dv/dual_encoder_speed_sampler_unit_test.sv
// self-checking testbench for the dual encoder speed sampler: directed, register and random traffic
`timescale 1ns / 100ps

module dual_encoder_speed_sampler_unit_test;
	import dess_pkg::*;

	localparam int RPM_FRAC    = RPM_FRAC_DEF;
	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 600;
	localparam int DRAIN_CYCLES = 100;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [15:0] signed_delta;
		logic        rejected;
		logic [15:0] kept;
		logic [31:0] total;
		logic [31:0] rpm;
	} wheel_t;

	typedef struct packed {
		wheel_t left;
		wheel_t right;
	} speed_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic signed [15:0]     left_raw = '0;
	logic signed [15:0]     right_raw = '0;
	logic [15:0]            period_ms = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic signed [15:0]     left_signed, right_signed, left_speed, right_speed;
	logic                   left_rejected, right_rejected;
	logic signed [31:0]     left_total, right_total, left_rpm, right_rpm;

	cfg_t          cfg_shadow;
	logic [31:0]   left_count = '0;
	logic [31:0]   right_count = '0;
	speed_result_t pending_speeds[$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int stall_hold = 0;
	int quiet_cycles = 0;
	int mismatches = 0;
	int results_checked = 0;
	int samples_sent = 0;
	int rejected_deltas = 0;
	int saturated_rpms = 0;

	dual_encoder_speed_sampler_unit dut (.*);

	always #6 clk = ~clk;

	function automatic int effective_limit();
		return (cfg_shadow.max_delta != 0) ? int'(cfg_shadow.max_delta) : int'(DEF_MAX_DELTA);
	endfunction

	function automatic wheel_t predict_wheel(input logic [15:0] raw, input logic inv,
			input logic [15:0] period, inout logic [31:0] count);
		wheel_t w;
		logic [16:0] mag;
		logic [63:0] ppr, ratio, quad, den, num, q;
		w.signed_delta = inv ? 16'(16'd0 - raw) : raw;
		// -32768 stays -32768 and has magnitude 32768
		mag = w.signed_delta[15] ? 17'h10000 - {1'b0, w.signed_delta} : {1'b0, w.signed_delta};
		w.rejected = (int'(mag) > effective_limit());
		w.kept = w.rejected ? 16'd0 : w.signed_delta;
		if (w.rejected) begin
			mag = '0;
			rejected_deltas++;
		end
		count = count + {{16{w.kept[15]}}, w.kept};
		w.total = count;
		if (period == 16'd0) begin
			w.rpm = '0;
		end else begin
			ppr   = (cfg_shadow.ppr != 0) ? 64'(cfg_shadow.ppr) : 64'(DEF_PPR);
			ratio = (cfg_shadow.ratio != 0) ? 64'(cfg_shadow.ratio) : 64'(DEF_RATIO);
			quad  = (cfg_shadow.quad != 0) ? 64'(cfg_shadow.quad) : 64'(DEF_QUAD);
			den = ppr * ratio * quad * 64'(period);
			num = (64'(mag) * 64'(MS_PER_MINUTE)) << RPM_FRAC;
			q = num / den;
			if (w.kept[15]) begin
				if (q > 64'h8000_0000) begin
					q = 64'h8000_0000;
					saturated_rpms++;
				end
				w.rpm = 32'(64'd0 - q);
			end else begin
				if (q > 64'h7fff_ffff) begin
					q = 64'h7fff_ffff;
					saturated_rpms++;
				end
				w.rpm = q[31:0];
			end
		end
		return w;
	endfunction

	function automatic speed_result_t predict_speed(input logic [15:0] l, input logic [15:0] r,
			input logic [15:0] period);
		speed_result_t s;
		s.left  = predict_wheel(l, cfg_shadow.left_inv, period, left_count);
		s.right = predict_wheel(r, cfg_shadow.right_inv, period, right_count);
		return s;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] seen);
		if (want !== seen) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d %s: expected %0h, got %0h", results_checked, name, want, seen);
		end
	endfunction

	function automatic void check_wheel(input string side, input wheel_t want, input wheel_t seen);
		check_field({side, "_signed"}, 32'(want.signed_delta), 32'(seen.signed_delta));
		check_field({side, "_rejected"}, 32'(want.rejected), 32'(seen.rejected));
		check_field({side, "_speed"}, 32'(want.kept), 32'(seen.kept));
		check_field({side, "_total"}, want.total, seen.total);
		check_field({side, "_rpm"}, want.rpm, seen.rpm);
	endfunction

	function automatic logic [15:0] random_delta();
		int lim;
		lim = effective_limit();
		case ($urandom_range(9))
			6: return 16'($urandom);
			7: begin
				case ($urandom_range(3))
					0: return 16'h8000;
					1: return 16'h7fff;
					2: return 16'h0000;
					default: return 16'hffff;
				endcase
			end
			8: return 16'($urandom_range(0, 20) - 10);
			// just inside or just outside the limit
			9: return ($urandom_range(1) == 0) ? 16'(lim + $urandom_range(1))
						: 16'(0 - lim - $urandom_range(1));
			default: return 16'($urandom_range(0, 2 * lim) - lim);
		endcase
	endfunction

	function automatic logic [15:0] random_period();
		case ($urandom_range(9))
			0: return 16'd0;
			1: return ($urandom_range(1) == 0) ? 16'd1 : 16'hffff;
			2, 3: return 16'($urandom);
			default: return 16'($urandom_range(1, 50));
		endcase
	endfunction

	function automatic logic [15:0] random_reg_value(input int hi);
		case ($urandom_range(5))
			0: return 16'h0000;
			1: return 16'hffff;
			2: return 16'($urandom);
			default: return 16'($urandom_range(1, hi));
		endcase
	endfunction

	// leaves cfg_we high; the caller lowers it after the last write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			REG_PPR:   cfg_shadow.ppr = data;
			REG_RATIO: cfg_shadow.ratio = data[9:0];
			REG_QUAD:  cfg_shadow.quad = data[2:0];
			REG_LINV:  cfg_shadow.left_inv = data[0];
			REG_RINV:  cfg_shadow.right_inv = data[0];
			REG_MAXD:  cfg_shadow.max_delta = data[14:0];
			default: ;
		endcase
	endtask

	task automatic send_sample(input logic [15:0] l, input logic [15:0] r, input logic [15:0] p);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 12)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		left_raw  <= l;
		right_raw <= r;
		period_ms <= p;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_speeds.push_back(predict_speed(l, r, p));
		samples_sent++;
	endtask

	task automatic finish_phase();
		in_valid <= 1'b0;
		while (pending_speeds.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed_extremes();
		send_sample(16'd0, 16'd0, 16'd1);
		send_sample(16'd1, 16'hffff, 16'd1);
		send_sample(16'd2000, -16'sd2000, 16'd10);
		send_sample(16'd2001, -16'sd2001, 16'd10);
		// most negative delta is rejected whatever the limit
		send_sample(16'h8000, 16'h8000, 16'd20);
		send_sample(16'h7fff, 16'h7fff, 16'd20);
		send_sample(16'hffff, 16'd1, 16'd0);
		send_sample(16'd1000, -16'sd1000, 16'hffff);
		send_sample(-16'sd2000, 16'd2000, 16'd1);
		send_sample(16'h5555, 16'haaaa, 16'h5555);
		finish_phase();
	endtask

	task automatic test_register_extremes();
		// smallest divisor: quotients overflow and saturate
		write_reg(REG_PPR, 16'd1);
		write_reg(REG_RATIO, 16'd1);
		write_reg(REG_QUAD, 16'd1);
		write_reg(REG_LINV, 16'd0);
		write_reg(REG_RINV, 16'd1);
		write_reg(REG_MAXD, 16'h7fff);
		cfg_we <= 1'b0;
		send_sample(16'd32767, -16'sd32767, 16'd1);
		send_sample(-16'sd32767, 16'd32767, 16'd1);
		send_sample(16'd100, -16'sd100, 16'hffff);
		finish_phase();

		// largest divisor, tightest limit
		write_reg(REG_PPR, 16'hffff);
		write_reg(REG_RATIO, 16'h03ff);
		write_reg(REG_QUAD, 16'd7);
		write_reg(REG_LINV, 16'd1);
		write_reg(REG_MAXD, 16'd1);
		cfg_we <= 1'b0;
		send_sample(16'd1, -16'sd1, 16'd1);
		send_sample(16'd2, -16'sd2, 16'd1);
		send_sample(16'hffff, 16'd1, 16'hffff);
		finish_phase();

		// quad values above four are used as written
		write_reg(REG_PPR, 16'd3);
		write_reg(REG_RATIO, 16'd2);
		write_reg(REG_MAXD, 16'd500);
		write_reg(REG_QUAD, 16'd5);
		cfg_we <= 1'b0;
		send_sample(16'd400, -16'sd333, 16'd7);
		finish_phase();
		write_reg(REG_QUAD, 16'd6);
		cfg_we <= 1'b0;
		send_sample(-16'sd499, 16'd500, 16'd3);
		finish_phase();

		// zero in ppr, ratio, quad and max_delta falls back to the defaults
		write_reg(REG_PPR, 16'd0);
		write_reg(REG_RATIO, 16'd0);
		write_reg(REG_QUAD, 16'd0);
		write_reg(REG_LINV, 16'd0);
		write_reg(REG_RINV, 16'd0);
		write_reg(REG_MAXD, 16'd0);
		cfg_we <= 1'b0;
		send_sample(16'd2000, 16'd2001, 16'd3);
		send_sample(-16'sd2000, -16'sd2001, 16'd3);
		finish_phase();

		// writes to unused indexes change nothing
		write_reg(REG_SPARE_LO, 16'hffff);
		write_reg(REG_SPARE_HI, 16'hffff);
		cfg_we <= 1'b0;
		send_sample(16'd500, -16'sd500, 16'd4);
		finish_phase();
	endtask

	task automatic test_output_backpressure();
		send_idle_pct = 0;
		stall_pct = 0;
		// receiver holds off long enough for the block to fill and stall its input
		@(negedge clk);
		stall_hold = HOLD_CYCLES;
		@(posedge clk);
		repeat (8)
			send_sample(random_delta(), random_delta(), random_period());
		finish_phase();
	endtask

	task automatic test_random_traffic(input int idle_pct, input int hold_pct, input int count);
		send_idle_pct = idle_pct;
		stall_pct = hold_pct;
		write_reg(REG_PPR, random_reg_value(40));
		write_reg(REG_RATIO, random_reg_value(40));
		write_reg(REG_QUAD, random_reg_value(7));
		write_reg(REG_LINV, random_reg_value(1));
		write_reg(REG_RINV, random_reg_value(1));
		write_reg(REG_MAXD, random_reg_value(32767));
		cfg_we <= 1'b0;
		repeat (count)
			send_sample(random_delta(), random_delta(), random_period());
		finish_phase();
	endtask

	// result checking, receiver stalls and the quiet-cycle count
	always @(posedge clk) begin
		speed_result_t seen, want;
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (out_valid && !out_stall) begin
				seen.left.signed_delta  = left_signed;
				seen.left.rejected      = left_rejected;
				seen.left.kept          = left_speed;
				seen.left.total         = left_total;
				seen.left.rpm           = left_rpm;
				seen.right.signed_delta = right_signed;
				seen.right.rejected     = right_rejected;
				seen.right.kept         = right_speed;
				seen.right.total        = right_total;
				seen.right.rpm          = right_rpm;
				if (pending_speeds.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d arrived with no item pending", results_checked);
				end else begin
					want = pending_speeds.pop_front();
					check_wheel("left", want.left, seen.left);
					check_wheel("right", want.right, seen.right);
				end
				results_checked++;
			end
			if (stall_hold > 0) begin
				out_stall <= 1'b1;
				stall_hold--;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
		$display("dual_encoder_speed_sampler_unit verification failed");
		$finish;
	end

	initial begin
		cfg_shadow.ppr       = DEF_PPR;
		cfg_shadow.ratio     = DEF_RATIO;
		cfg_shadow.quad      = DEF_QUAD;
		cfg_shadow.left_inv  = DEF_LEFT_INV;
		cfg_shadow.right_inv = DEF_RIGHT_INV;
		cfg_shadow.max_delta = DEF_MAX_DELTA;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_extremes();
		test_register_extremes();
		test_output_backpressure();
		test_random_traffic(0, 0, 255);
		test_random_traffic(54, 0, 255);
		test_random_traffic(0, 54, 255);
		test_random_traffic(27, 27, 255);

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d samples sent under directed, saturating, back-pressured and random traffic",
			samples_sent);
		$display("%0d results checked, %0d deltas rejected, %0d rpm values saturated, %0d mismatches",
			results_checked, rejected_deltas, saturated_rpms, mismatches);
		if (mismatches == 0 && pending_speeds.size() == 0)
			$display("dual_encoder_speed_sampler_unit verification clean");
		else
			$display("dual_encoder_speed_sampler_unit verification failed");
		$finish;
	end

endmodule
